FILE: sv/kmc_pkg.sv
// Shared types, constants and base coding for the k-mer histogram counter.
package kmc_pkg;

   localparam int MAX_K_DEF      = 8;
   localparam int COUNT_BITS_DEF = 32;
   localparam int KMER_LEN_W     = 4;
   localparam int CODE_W         = 16;
   localparam int COUNT_W        = 32;
   localparam int CMD_DEPTH      = 4;

   localparam logic       ACT_FEED = 1'b0;
   localparam logic       ACT_DUMP = 1'b1;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic       action;
      logic [7:0] symbol;
      logic       read_start;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  kmer_code;
      logic [COUNT_W-1:0] kmer_count;
      logic               dump_done;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_INC,
      BK_SCAN
   } back_state_type;

   // A, N and anything unrecognized fold to the A code.
   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] code;
      unique case (ch)
         CHAR_C:  code = BASE_C;
         CHAR_G:  code = BASE_G;
         CHAR_T:  code = BASE_T;
         default: code = BASE_A;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/kmc_front.sv
// Front end: takes requests, tracks the base window and issues counter commands.
module kmc_front
   import kmc_pkg::*;
#(
   parameter  int MAX_K  = MAX_K_DEF,
   localparam int BW     = $clog2(MAX_K + 1),
   localparam int KLEN_W = (BW > KMER_LEN_W) ? BW : KMER_LEN_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   input  logic [KLEN_W-1:0]      kmer_len,
   input  logic                   clear_busy,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output logic                   cmd_dump,
   output logic [2*MAX_K-1:0]     cmd_key
);

   localparam int WIN_BITS = 2 * MAX_K;
   localparam int CMP_W    = (KLEN_W > BW) ? KLEN_W : BW;

   logic [WIN_BITS-1:0] window_ff, window_in, window_base;
   logic [BW-1:0]       bases_ff, bases_in, bases_base;
   logic [WIN_BITS+1:0] window_cat;
   logic [WIN_BITS-1:0] kmask;
   logic [BW-1:0]       eff_k;
   logic                accept;
   logic                count_en;

   assign req_full = cmd_full | clear_busy;
   assign accept   = req_push & ~req_full;

   // Out-of-range lengths clamp to 1..MAX_K.
   always_comb begin
      if (kmer_len == '0)
         eff_k = BW'(1);
      else if (CMP_W'(kmer_len) > CMP_W'(MAX_K))
         eff_k = BW'(MAX_K);
      else
         eff_k = BW'(kmer_len);
   end

   always_comb begin
      for (int i = 0; i < MAX_K; i++)
         kmask[2*i +: 2] = (i < int'(eff_k)) ? 2'b11 : 2'b00;
   end

   always_comb begin
      window_base = req_data.read_start ? '0 : window_ff;
      bases_base  = req_data.read_start ? '0 : bases_ff;
      window_cat  = {window_base, base_code(req_data.symbol)};
      window_in   = window_cat[WIN_BITS-1:0];
      bases_in    = (bases_base < BW'(MAX_K)) ? bases_base + 1'b1 : bases_base;
      count_en    = (bases_in >= eff_k);
   end

   always_comb begin
      cmd_dump = (req_data.action == ACT_DUMP);
      cmd_key  = window_in & kmask;
      cmd_push = accept & (cmd_dump | count_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         bases_ff  <= '0;
      end else if (accept && req_data.action == ACT_FEED) begin
         window_ff <= window_in;
         bases_ff  <= bases_in;
      end
   end

endmodule

FILE: sv/kmc_cmd_fifo.sv
// Short command queue between the front end and the counter engine.
module kmc_cmd_fifo
   import kmc_pkg::*;
#(
   parameter int WIDTH = 2 * MAX_K_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(CMD_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop)
         fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: sv/kmc_back.sv
// Counter engine: count memory, clear sweep, increments and dump scan.
module kmc_back
   import kmc_pkg::*;
#(
   parameter int MAX_K      = MAX_K_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  logic                 cmd_dump,
   input  logic [2*MAX_K-1:0]   cmd_key,
   output logic                 cmd_pop,
   output logic                 clear_busy,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data
);

   localparam int     ADDR_BITS  = 2 * MAX_K;
   localparam longint TABLE_SIZE = 64'd1 << ADDR_BITS;

   logic [COUNT_BITS-1:0] mem_ff [0:TABLE_SIZE-1];
   logic [COUNT_BITS-1:0] rd_data_ff;

   back_state_type        state_ff, state_in;
   logic [ADDR_BITS:0]    cursor_ff, cursor_in;
   logic [ADDR_BITS-1:0]  scan_key_ff, scan_key_in;
   logic [ADDR_BITS-1:0]  inc_key_ff, inc_key_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en;
   logic                  emit;
   rsp_type               emit_data, done_data;

   assign clear_busy = (state_ff == BK_CLEAR);
   assign rsp_empty  = ~rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      done_data            = '0;
      done_data.dump_done  = 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      scan_key_in = scan_key_ff;
      inc_key_in  = inc_key_ff;
      clr_addr_in = clr_addr_ff;
      rd_addr     = cmd_key;
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_data   = done_data;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff)
               state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (cmd_valid) begin
               if (!cmd_dump) begin
                  cmd_pop    = 1'b1;
                  inc_key_in = cmd_key;
                  state_in   = BK_INC;
               end else if (!rsp_valid_ff) begin
                  cmd_pop = 1'b1;
                  if (cursor_ff[ADDR_BITS]) begin
                     // pass already complete: report done and rewind
                     emit      = 1'b1;
                     cursor_in = '0;
                  end else begin
                     rd_addr     = cursor_ff[ADDR_BITS-1:0];
                     scan_key_in = cursor_ff[ADDR_BITS-1:0];
                     cursor_in   = cursor_ff + 1'b1;
                     state_in    = BK_SCAN;
                  end
               end
            end
         end
         BK_INC: begin
            wr_en    = 1'b1;
            wr_addr  = inc_key_ff;
            wr_data  = (&rd_data_ff) ? rd_data_ff : rd_data_ff + 1'b1;
            state_in = BK_IDLE;
         end
         BK_SCAN: begin
            // rd_data_ff holds the entry at scan_key_ff
            if (rd_data_ff != '0) begin
               emit                 = 1'b1;
               emit_data.kmer_code  = CODE_W'(scan_key_ff);
               emit_data.kmer_count = COUNT_W'(rd_data_ff);
               emit_data.dump_done  = 1'b0;
               state_in             = BK_IDLE;
            end else if (cursor_ff[ADDR_BITS]) begin
               emit      = 1'b1;
               cursor_in = '0;
               state_in  = BK_IDLE;
            end else begin
               rd_addr     = cursor_ff[ADDR_BITS-1:0];
               scan_key_in = cursor_ff[ADDR_BITS-1:0];
               cursor_in   = cursor_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         cursor_ff    <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cursor_ff   <= cursor_in;
         clr_addr_ff <= clr_addr_in;
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_pop)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      scan_key_ff <= scan_key_in;
      inc_key_ff  <= inc_key_in;
      if (emit)
         rsp_data_ff <= emit_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/kmer_histogram_counter_unit.sv
// Top level of the k-mer histogram counter.
//
// Requests enter on a queue-style port (req_push / req_full). A feed request
// shifts one base into the rolling window; once the read has k bases it bumps
// the saturating counter of the current k-mer. A dump request returns the next
// nonzero counter in ascending key order, or a done reply that rewinds the pass.
// Replies leave on rsp_data while rsp_empty is low and are taken with rsp_pop.
// csr_valid / csr_ready write the k-mer length; write it only while idle.
//
// Reset clears the window and the dump cursor, then sweeps the count memory
// one entry per cycle with req_full high. A counted base takes a memory
// read, then a write in the engine; bases that count nothing never reach it.
// A dump reads entries in ascending order, skipping zero ones, until it finds
// a nonzero entry or the end of the key space. The 4-deep command queue lets
// the front keep taking requests while the engine is busy. A reply not taken
// stalls the next dump and every command behind it; feeds ahead still proceed.
module kmer_histogram_counter_unit
   import kmc_pkg::*;
#(
   parameter int MAX_K      = MAX_K_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [KMER_LEN_W-1:0] csr_data
);

   localparam int ADDR_BITS = 2 * MAX_K;
   localparam int BW        = $clog2(MAX_K + 1);
   localparam int KLEN_W    = (BW > KMER_LEN_W) ? BW : KMER_LEN_W;

   logic [KLEN_W-1:0]    kmer_len_ff;
   logic                 clear_busy;
   logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic                 push_dump, head_dump;
   logic [ADDR_BITS-1:0] push_key, head_key;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         kmer_len_ff <= KLEN_W'(MAX_K);
      else if (csr_valid && csr_ready)
         kmer_len_ff <= KLEN_W'(csr_data);
   end

   kmc_front #(
      .MAX_K (MAX_K)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .kmer_len   (kmer_len_ff),
      .clear_busy (clear_busy),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_dump   (push_dump),
      .cmd_key    (push_key)
   );

   kmc_cmd_fifo #(
      .WIDTH (ADDR_BITS + 1)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_dump, push_key}),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  ({head_dump, head_key}),
      .empty     (cmd_empty)
   );

   kmc_back #(
      .MAX_K      (MAX_K),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (~cmd_empty),
      .cmd_dump   (head_dump),
      .cmd_key    (head_key),
      .cmd_pop    (cmd_pop),
      .clear_busy (clear_busy),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_full)
      else $error("request port open during memory clear");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");

   a_reset_starts_clear: assert property (@(posedge clock)
      reset |=> (clear_busy && rsp_empty))
      else $error("reset did not start the clear sweep");

   a_pop_needs_command: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("engine popped an empty command queue");
`endif

endmodule

FILE: dv/kmer_count_checker.sv
`timescale 1ns / 1ps
// Reply checker for the k-mer histogram counter: tracks the count memory and compares dump replies.
module kmer_count_checker
   import kmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   input  logic                  req_full,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [KMER_LEN_W-1:0] csr_data,
   output int unsigned           fail_count,
   output int unsigned           backlog
);

   localparam int unsigned KEY_SPACE = 1 << (2 * MAX_K_DEF);
   localparam int unsigned BLOCKS    = KEY_SPACE / 256;

   logic [COUNT_W-1:0]     hist [KEY_SPACE];
   int unsigned            block_used [BLOCKS];
   logic [2*MAX_K_DEF-1:0] window;
   int unsigned            read_len;
   int unsigned            cursor;
   logic [KMER_LEN_W-1:0]  kmer_len;
   rsp_type                due_replies [$];
   int unsigned            mismatches = 0;

   assign fail_count = mismatches;

   always @(posedge clock) begin : track
      rsp_type     want;
      int unsigned k;
      int unsigned key;
      logic [1:0]  code;
      if (reset) begin
         for (int i = 0; i < KEY_SPACE; i++) hist[i] = '0;
         for (int i = 0; i < BLOCKS; i++) block_used[i] = 0;
         window   = '0;
         read_len = 0;
         cursor   = 0;
         kmer_len = KMER_LEN_W'(MAX_K_DEF);
         due_replies.delete();
      end else begin
         // replies first: one taken at this edge always belongs to an earlier dump
         if (rsp_pop && !rsp_empty) begin
            if (due_replies.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected reply: code %h count %0d done %0b", $time,
                           rsp_data.kmer_code, rsp_data.kmer_count, rsp_data.dump_done);
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_data.kmer_code !== want.kmer_code ||
                   rsp_data.kmer_count !== want.kmer_count ||
                   rsp_data.dump_done !== want.dump_done) begin
                  if (mismatches < 10)
                     $display({"%0t: reply mismatch: expected code %h count %0d done %0b,",
                               " got code %h count %0d done %0b"},
                              $time, want.kmer_code, want.kmer_count, want.dump_done,
                              rsp_data.kmer_code, rsp_data.kmer_count, rsp_data.dump_done);
                  mismatches++;
               end
            end
         end

         if (csr_valid && csr_ready) kmer_len = csr_data;

         if (req_push && !req_full) begin
            if (req_data.action == ACT_FEED) begin
               // 0 behaves as 1, anything past the built maximum as the maximum
               if (kmer_len == 0) k = 1;
               else if (kmer_len > MAX_K_DEF) k = MAX_K_DEF;
               else k = kmer_len;
               if (req_data.read_start) begin
                  window   = '0;
                  read_len = 0;
               end
               case (req_data.symbol)
                  CHAR_C:  code = BASE_C;
                  CHAR_G:  code = BASE_G;
                  CHAR_T:  code = BASE_T;
                  default: code = BASE_A;
               endcase
               window = {window[2*MAX_K_DEF-3:0], code};
               if (read_len < MAX_K_DEF) read_len++;
               if (read_len >= k) begin
                  key = window & ((1 << (2 * k)) - 1);
                  if (hist[key] != '1) begin
                     if (hist[key] == 0) block_used[key / 256]++;
                     hist[key]++;
                  end
               end
            end else begin
               key = cursor;
               while (key < KEY_SPACE && hist[key] == 0) begin
                  // skip whole empty blocks
                  if (key % 256 == 0 && block_used[key / 256] == 0) key += 256;
                  else key++;
               end
               want = '0;
               if (key < KEY_SPACE) begin
                  want.kmer_code  = CODE_W'(key);
                  want.kmer_count = hist[key];
                  cursor = key + 1;
               end else begin
                  want.dump_done = 1'b1;
                  cursor = 0;
               end
               due_replies.push_back(want);
            end
         end
      end
      backlog <= due_replies.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the k-mer histogram counter testbench: clock, reset, request traffic and verdict.
module testbench
   import kmc_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int unsigned PHASE_ITEMS  = 115;
   localparam int unsigned DONE_BUDGET  = 8;
   localparam int unsigned DRAIN_CYCLES = 32;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   req_type               req_data  = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [KMER_LEN_W-1:0] csr_data  = '0;

   int unsigned fail_count;
   int unsigned backlog;
   int unsigned cycles          = 0;
   int unsigned feeds_sent      = 0;
   int unsigned dumps_sent      = 0;
   int unsigned replies_taken   = 0;
   int unsigned dones_seen      = 0;
   int unsigned stall_left      = 0;
   int unsigned burst_left      = 0;
   int unsigned phase_done_base = 0;
   logic        calm            = 1'b0;
   int unsigned klen_plan [12]  = '{1, 0, 2, 3, 4, 15, 5, 6, 7, 8, 11, 8};

   kmer_histogram_counter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   kmer_count_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // reply side: pops with random stalls, or every cycle in calm phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            replies_taken <= replies_taken + 1;
            if (rsp_data.dump_done) dones_seen <= dones_seen + 1;
         end
         if (calm || stall_left == 0) begin
            rsp_pop <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
         end else begin
            rsp_pop <= 1'b0;
            stall_left--;
         end
      end
   end

   task automatic send_request(input logic act, input logic [7:0] sym, input logic start);
      req_type r;
      if (burst_left == 0) begin
         if (!calm) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      r.action     = act;
      r.symbol     = sym;
      r.read_start = start;
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (act == ACT_DUMP) dumps_sent++;
      else feeds_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (backlog != 0);
   endtask

   task automatic write_kmer_len(input logic [KMER_LEN_W-1:0] len);
      req_push <= 1'b0;
      wait_drained();
      // counted bases may still sit in the engine's read-modify-write
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // full passes over the key space are slow, so cap them
   function automatic logic dump_allowed();
      return (dones_seen == phase_done_base) && (dones_seen < DONE_BUDGET);
   endfunction

   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(0, 9))
         0, 1:    return "A";
         2, 3:    return CHAR_C;
         4, 5:    return CHAR_G;
         6, 7:    return CHAR_T;
         8:       return "N";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned ph;
      int unsigned j;
      int unsigned len;
      int unsigned target;
      int unsigned plen;
      int unsigned roll;
      logic        fresh;
      logic        motif_on;
      logic [7:0]  motif [3];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, at the reset length of 8
      send_request(ACT_DUMP, 8'h00, 1'b0);          // empty memory: done at once
      send_request(ACT_FEED, "A", 1'b1);
      send_request(ACT_FEED, CHAR_C, 1'b0);
      send_request(ACT_FEED, CHAR_G, 1'b0);
      send_request(ACT_FEED, CHAR_T, 1'b0);
      send_request(ACT_FEED, "N", 1'b0);
      send_request(ACT_FEED, "a", 1'b0);            // lowercase folds to A
      send_request(ACT_FEED, 8'hFF, 1'b0);          // still short of k: nothing counted
      send_request(ACT_FEED, CHAR_T, 1'b0);
      send_request(ACT_FEED, 8'h00, 1'b0);
      send_request(ACT_DUMP, CHAR_G, 1'b1);         // start flag on a dump is ignored
      for (j = 0; j < 9; j++) send_request(ACT_FEED, CHAR_T, j == 0);  // top key, twice
      repeat (3)
         send_request(ACT_DUMP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      for (ph = 0; ph < 12; ph++) begin
         write_kmer_len(KMER_LEN_W'(klen_plan[ph]));
         calm <= (ph % 4 == 3);
         phase_done_base = dones_seen;
         target = feeds_sent + dumps_sent + PHASE_ITEMS;
         while (feeds_sent + dumps_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               send_request(ACT_FEED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (roll < 12 && dump_allowed()) begin
               send_request(ACT_DUMP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
               fresh = ($urandom_range(0, 9) != 0);
               motif_on = ($urandom_range(0, 3) == 0);
               plen = $urandom_range(1, 3);
               for (j = 0; j < 3; j++) motif[j] = pick_symbol();
               for (j = 0; j < len; j++) begin
                  send_request(ACT_FEED, motif_on ? motif[j % plen] : pick_symbol(),
                               fresh && j == 0);
                  if (dump_allowed() && $urandom_range(0, 99) < 10)
                     send_request(ACT_DUMP, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
               end
            end
         end
      end

      req_push <= 1'b0;
      wait_drained();
      repeat (64) @(posedge clock);
      $display("Covered %0d bases and %0d dump requests over 13 length settings (0 to 15).",
               feeds_sent, dumps_sent);
      $display("%0d replies checked, %0d dump passes ran to the end of the key space.",
               replies_taken, dones_seen);
      if (fail_count == 0 && backlog == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
sv/kmc_pkg.sv
sv/kmc_front.sv
sv/kmc_cmd_fifo.sv
sv/kmc_back.sv
sv/kmer_histogram_counter_unit.sv
dv/kmer_count_checker.sv
dv/testbench.sv
